FILE: hdl/tmss_pkg.sv
package tmss_pkg;

    // Register map of the configuration port, one 32-bit word per register.
    localparam int unsigned ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_DRIVE_GAIN_ONE     = 3'd0,
        REG_DRIVE_GAIN_TWO     = 3'd1,
        REG_SPRING_GAIN        = 3'd2,
        REG_TORQUE_GAIN_ONE    = 3'd3,
        REG_TORQUE_GAIN_TWO    = 3'd4,
        REG_VELOCITY_SCALE_ONE = 3'd5,
        REG_VELOCITY_SCALE_TWO = 3'd6,
        REG_TIME_STEP          = 3'd7
    } t_reg_idx;

    // Signed Q16.16 value.
    typedef logic signed [31:0] t_q;

    localparam t_q          GAIN_RESET = 32'sd65536;
    localparam logic [30:0] STEP_RESET = 31'd655;

    // Configuration as seen by the datapath.
    typedef struct packed {
        t_q          drive_gain_one;
        t_q          drive_gain_two;
        t_q          spring_gain;
        t_q          torque_gain_one;
        t_q          torque_gain_two;
        t_q          velocity_scale_one;
        t_q          velocity_scale_two;
        logic [30:0] time_step;
    } t_cfg;

    // Operations that go through the shared multiplier pipeline.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_D1,
        OP_D2,
        OP_COUP,
        OP_OLD1,
        OP_OLD2,
        OP_TQ1,
        OP_TQ2,
        OP_V1,
        OP_V2,
        OP_NEW1,
        OP_NEW2,
        OP_P1,
        OP_P2
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic load_out;
        t_op  op;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    // Saturate a wide signed value to the 32-bit signed range.
    function automatic t_q sat32(input logic signed [65:0] v);
        t_q r;
        if (v > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/tmss_if.sv
// Input item channel: two drive samples.
interface tmss_drive_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] drive_one;
    logic signed [31:0] drive_two;

    modport source(output valid, output drive_one, output drive_two, input ready);
    modport sink(input valid, input drive_one, input drive_two, output ready);
endinterface

// Result item channel: both disk angles.
interface tmss_angle_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] angle_one;
    logic signed [31:0] angle_two;

    modport source(output valid, output angle_one, output angle_two, input ready);
    modport sink(input valid, input angle_one, input angle_two, output ready);
endinterface

FILE: hdl/tmss_regs.sv
module tmss_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tmss_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output tmss_pkg::t_cfg                 o_cfg
);

    tmss_pkg::t_cfg     r_cfg;
    tmss_pkg::t_reg_idx idx;
    logic               wr;

    assign idx    = tmss_pkg::t_reg_idx'(paddr[tmss_pkg::ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; bits above a register's width are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_gain_one     <= tmss_pkg::GAIN_RESET;
            r_cfg.drive_gain_two     <= tmss_pkg::GAIN_RESET;
            r_cfg.spring_gain        <= tmss_pkg::GAIN_RESET;
            r_cfg.torque_gain_one    <= tmss_pkg::GAIN_RESET;
            r_cfg.torque_gain_two    <= tmss_pkg::GAIN_RESET;
            r_cfg.velocity_scale_one <= tmss_pkg::GAIN_RESET;
            r_cfg.velocity_scale_two <= tmss_pkg::GAIN_RESET;
            r_cfg.time_step          <= tmss_pkg::STEP_RESET;
        end else if (wr) begin
            case (idx)
                tmss_pkg::REG_DRIVE_GAIN_ONE:     r_cfg.drive_gain_one     <= pwdata;
                tmss_pkg::REG_DRIVE_GAIN_TWO:     r_cfg.drive_gain_two     <= pwdata;
                tmss_pkg::REG_SPRING_GAIN:        r_cfg.spring_gain        <= pwdata;
                tmss_pkg::REG_TORQUE_GAIN_ONE:    r_cfg.torque_gain_one    <= pwdata;
                tmss_pkg::REG_TORQUE_GAIN_TWO:    r_cfg.torque_gain_two    <= pwdata;
                tmss_pkg::REG_VELOCITY_SCALE_ONE: r_cfg.velocity_scale_one <= pwdata;
                tmss_pkg::REG_VELOCITY_SCALE_TWO: r_cfg.velocity_scale_two <= pwdata;
                tmss_pkg::REG_TIME_STEP:          r_cfg.time_step          <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (idx)
            tmss_pkg::REG_DRIVE_GAIN_ONE:     prdata = r_cfg.drive_gain_one;
            tmss_pkg::REG_DRIVE_GAIN_TWO:     prdata = r_cfg.drive_gain_two;
            tmss_pkg::REG_SPRING_GAIN:        prdata = r_cfg.spring_gain;
            tmss_pkg::REG_TORQUE_GAIN_ONE:    prdata = r_cfg.torque_gain_one;
            tmss_pkg::REG_TORQUE_GAIN_TWO:    prdata = r_cfg.torque_gain_two;
            tmss_pkg::REG_VELOCITY_SCALE_ONE: prdata = r_cfg.velocity_scale_one;
            tmss_pkg::REG_VELOCITY_SCALE_TWO: prdata = r_cfg.velocity_scale_two;
            tmss_pkg::REG_TIME_STEP:          prdata = {1'b0, r_cfg.time_step};
            default:                          prdata = 32'd0;
        endcase
    end

endmodule

FILE: hdl/tmss_ctrl.sv
module tmss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tmss_pkg::t_status i_status,
    output tmss_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    // Slot of the final write-back of a step, after the last issue.
    localparam logic [4:0] LAST_SLOT = 5'd17;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;

    // Issue schedule. A result is usable only once it has passed the operand and
    // product registers and been written back, so the dependent operations are spaced out and the gaps are idle slots.
    function automatic tmss_pkg::t_op slot_op(input logic [4:0] slot);
        tmss_pkg::t_op op;
        case (slot)
            5'd0:    op = tmss_pkg::OP_D1;
            5'd1:    op = tmss_pkg::OP_D2;
            5'd2:    op = tmss_pkg::OP_COUP;
            5'd3:    op = tmss_pkg::OP_OLD1;
            5'd4:    op = tmss_pkg::OP_OLD2;
            5'd5:    op = tmss_pkg::OP_TQ1;
            5'd6:    op = tmss_pkg::OP_TQ2;
            5'd8:    op = tmss_pkg::OP_V1;
            5'd9:    op = tmss_pkg::OP_V2;
            5'd11:   op = tmss_pkg::OP_NEW1;
            5'd12:   op = tmss_pkg::OP_NEW2;
            5'd14:   op = tmss_pkg::OP_P1;
            5'd15:   op = tmss_pkg::OP_P2;
            default: op = tmss_pkg::OP_NONE;
        endcase
        return op;
    endfunction

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_in_ready     = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.load_out = 1'b0;
        o_cmd.op       = tmss_pkg::OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_cnt         = 5'd0;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.op = slot_op(r_cnt);
                n_cnt    = r_cnt + 5'd1;
                if (r_cnt == LAST_SLOT) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

FILE: hdl/tmss_dp.sv
module tmss_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tmss_pkg::t_cfg     i_cfg,
    input  tmss_pkg::t_cmd     i_cmd,
    output tmss_pkg::t_status  o_status,
    input  logic signed [31:0] i_drive_one,
    input  logic signed [31:0] i_drive_two,
    output logic signed [31:0] o_angle_one,
    output logic signed [31:0] o_angle_two,
    output logic               o_out_valid,
    input  logic               i_out_ready
);

    // Model state and intermediate results.
    tmss_pkg::t_q r_v1, r_v2, r_p1, r_p2, r_pt1, r_pt2;
    tmss_pkg::t_q r_drive1, r_drive2;
    tmss_pkg::t_q r_d1, r_d2, r_coup, r_tq1, r_tq2;
    tmss_pkg::t_q r_old1, r_old2, r_new1, r_new2;

    // Multiplier pipeline.
    logic signed [32:0] r_opa, n_opa;
    logic signed [31:0] r_opb, n_opb;
    logic signed [64:0] r_prod;
    tmss_pkg::t_op      r_op_s1, r_op_s2;

    // Output register.
    logic               r_out_valid;
    tmss_pkg::t_q       r_angle_one, r_angle_two;

    // Write-back stage signals.
    logic               is_trap;
    logic signed [65:0] rnd;
    logic signed [65:0] q;
    tmss_pkg::t_q       acc;
    tmss_pkg::t_q       res;
    logic signed [32:0] step33;

    assign step33 = {2'b00, i_cfg.time_step};

    // Operand stage: sums and differences in front of the multiplier.
    always_comb begin
        n_opa = '0;
        n_opb = '0;
        case (i_cmd.op)
            tmss_pkg::OP_D1: begin
                n_opa = 33'(r_drive1);
                n_opb = i_cfg.drive_gain_one;
            end
            tmss_pkg::OP_D2: begin
                n_opa = 33'(r_drive2);
                n_opb = i_cfg.drive_gain_two;
            end
            tmss_pkg::OP_COUP: begin
                n_opa = 33'(tmss_pkg::sat32(66'(r_p1) + 66'(r_p2)));
                n_opb = i_cfg.spring_gain;
            end
            tmss_pkg::OP_OLD1, tmss_pkg::OP_NEW1: begin
                n_opa = 33'(r_v1);
                n_opb = i_cfg.velocity_scale_one;
            end
            tmss_pkg::OP_OLD2, tmss_pkg::OP_NEW2: begin
                n_opa = 33'(r_v2);
                n_opb = i_cfg.velocity_scale_two;
            end
            tmss_pkg::OP_TQ1: begin
                n_opa = 33'(tmss_pkg::sat32(66'(r_d1) - 66'(r_v1) - 66'(r_coup)));
                n_opb = i_cfg.torque_gain_one;
            end
            tmss_pkg::OP_TQ2: begin
                n_opa = 33'(tmss_pkg::sat32(66'(r_d2) - 66'(r_v2) + 66'(r_coup)));
                n_opb = i_cfg.torque_gain_two;
            end
            tmss_pkg::OP_V1: begin
                n_opa = 33'(r_pt1) + 33'(r_tq1);
                n_opb = step33[31:0];
            end
            tmss_pkg::OP_V2: begin
                n_opa = 33'(r_pt2) + 33'(r_tq2);
                n_opb = step33[31:0];
            end
            tmss_pkg::OP_P1: begin
                n_opa = 33'(r_old1) + 33'(r_new1);
                n_opb = step33[31:0];
            end
            tmss_pkg::OP_P2: begin
                n_opa = 33'(r_old2) + 33'(r_new2);
                n_opb = step33[31:0];
            end
            default: ;
        endcase
    end

    // Operation tags move along with the operands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_s1 <= tmss_pkg::OP_NONE;
            r_op_s2 <= tmss_pkg::OP_NONE;
        end else begin
            r_op_s1 <= i_cmd.op;
            r_op_s2 <= r_op_s1;
        end
    end

    // Operand and product registers.
    always_ff @(posedge i_clk) begin
        r_opa  <= n_opa;
        r_opb  <= n_opb;
        r_prod <= r_opa * r_opb;
    end

    // Write-back: round half up, shift by 16 for a product or by 17 for a
    // trapezoid step, then saturate, adding the integrator value first.
    always_comb begin
        is_trap = (r_op_s2 == tmss_pkg::OP_V1) || (r_op_s2 == tmss_pkg::OP_V2) ||
                  (r_op_s2 == tmss_pkg::OP_P1) || (r_op_s2 == tmss_pkg::OP_P2);
        rnd = 66'(r_prod) + (is_trap ? 66'sd65536 : 66'sd32768);
        q   = is_trap ? (rnd >>> 17) : (rnd >>> 16);
        case (r_op_s2)
            tmss_pkg::OP_V1: acc = r_v1;
            tmss_pkg::OP_V2: acc = r_v2;
            tmss_pkg::OP_P1: acc = r_p1;
            tmss_pkg::OP_P2: acc = r_p2;
            default:         acc = '0;
        endcase
        res = is_trap ? tmss_pkg::sat32(q + 66'(acc)) : tmss_pkg::sat32(q);
    end

    // Model state, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= '0;
            r_v2  <= '0;
            r_p1  <= '0;
            r_p2  <= '0;
            r_pt1 <= '0;
            r_pt2 <= '0;
        end else begin
            case (r_op_s2)
                tmss_pkg::OP_V1: begin
                    r_v1  <= res;
                    r_pt1 <= r_tq1;
                end
                tmss_pkg::OP_V2: begin
                    r_v2  <= res;
                    r_pt2 <= r_tq2;
                end
                tmss_pkg::OP_P1: r_p1 <= res;
                tmss_pkg::OP_P2: r_p2 <= res;
                default: ;
            endcase
        end
    end

    // Intermediate results and the captured input item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_drive1 <= i_drive_one;
            r_drive2 <= i_drive_two;
        end
        case (r_op_s2)
            tmss_pkg::OP_D1:   r_d1   <= res;
            tmss_pkg::OP_D2:   r_d2   <= res;
            tmss_pkg::OP_COUP: r_coup <= res;
            tmss_pkg::OP_TQ1:  r_tq1  <= res;
            tmss_pkg::OP_TQ2:  r_tq2  <= res;
            tmss_pkg::OP_OLD1: r_old1 <= res;
            tmss_pkg::OP_OLD2: r_old2 <= res;
            tmss_pkg::OP_NEW1: r_new1 <= res;
            tmss_pkg::OP_NEW2: r_new2 <= res;
            default: ;
        endcase
    end

    // Output register: holds a finished item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_angle_one <= r_p1;
            r_angle_two <= r_p2;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_angle_one       = r_angle_one;
    assign o_angle_two       = r_angle_two;

endmodule

FILE: hdl/two_mass_spring_model_step.sv
// One simulation step of a two-disk spring model per input item: both drive
// samples are scaled, combined with the disk velocities and the spring term
// on the angle sum, turned into torques, and velocity and angle are
// integrated by the trapezoid rule in signed Q16.16 with saturation. Each
// item runs to completion, its thirteen dependent multiplications sharing
// one three-stage multiplier pipeline, and the next item can be accepted
// in the cycle in which the result becomes valid. A result waiting in the
// output register does not block the next accept, but a finished step
// waits for the register to be free. Configuration registers sit at byte
// address 4*i; the user must write them only while idle (not enforced).
module two_mass_spring_model_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tmss_drive_if.sink                  i_drive,
    tmss_angle_if.source                o_angle,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmss_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    tmss_pkg::t_cfg    cfg;
    tmss_pkg::t_cmd    cmd;
    tmss_pkg::t_status status;
    logic              in_ready;
    logic              out_valid;
    logic signed [31:0] angle_one;
    logic signed [31:0] angle_two;

    // Configuration registers.
    tmss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Step sequencer.
    tmss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_drive.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic and state.
    tmss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_drive_one (i_drive.drive_one),
        .i_drive_two (i_drive.drive_two),
        .o_angle_one (angle_one),
        .o_angle_two (angle_two),
        .o_out_valid (out_valid),
        .i_out_ready (o_angle.ready)
    );

    assign i_drive.ready     = in_ready;
    assign o_angle.valid     = out_valid;
    assign o_angle.angle_one = angle_one;
    assign o_angle.angle_two = angle_two;

endmodule

FILE: hdl/tmss_checker.sv
module tmss_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic signed [31:0]          i_angle_one,
    input logic                        i_psel,
    input logic                        i_penable,
    input logic                        i_pwrite,
    input logic [tmss_pkg::ADDR_W-1:0] i_paddr,
    input logic [31:0]                 i_pwdata,
    input logic [31:0]                 i_prdata
);

    logic in_acc;
    logic cfg_wr;

    assign in_acc = i_in_valid && i_in_ready;
    assign cfg_wr = i_psel && i_penable && i_pwrite;

    // A result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_angle_one)))
        else $error("result item dropped or changed while stalled");

    // One item at a time: no new accept right after an accept.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input item accepted while a step is in progress");

    // A new result only appears at the end of a step, when input is held off.
    a_out_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result item appeared outside the end of a step");

    // A register reads back what was written to it, masked to its width.
    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr ##1 (i_psel && !i_pwrite &&
                     i_paddr[tmss_pkg::ADDR_W-1:2] == $past(i_paddr[tmss_pkg::ADDR_W-1:2])))
        |-> (i_prdata == (($past(i_paddr[tmss_pkg::ADDR_W-1:2]) == tmss_pkg::REG_TIME_STEP)
                          ? {1'b0, $past(i_pwdata[30:0])} : $past(i_pwdata))))
        else $error("register read back differs from the value written");

endmodule

bind two_mass_spring_model_step tmss_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_drive.valid),
    .i_in_ready  (i_drive.ready),
    .i_out_valid (o_angle.valid),
    .i_out_ready (o_angle.ready),
    .i_angle_one (o_angle.angle_one),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata)
);
